// ===== src/fqi_pkg.sv =====
// fqi_pkg: shared types and codes for the positional-insert queue
// no dependencies
`timescale 1ns / 1ps
package fqi_pkg;

  localparam int VALUE_W = 64;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int OCC_W   = 6;

  localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  localparam logic signed [VALUE_W-1:0] NO_VALUE = '1;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUT,
    CMD_POP
  } cell_cmd_t;

endpackage

// ===== src/fqi_cell.sv =====
// fqi_cell: one storage slot of the queue chain
// takes its neighbor's word on a shift, the new word at its own index
// depends on fqi_pkg
`timescale 1ns / 1ps
module fqi_cell #(
  parameter int PW = 6
) (
  input  logic              clk,
  input  fqi_pkg::cell_cmd_t cmd,
  input  logic [PW-1:0]     pos,
  input  logic [PW-1:0]     idx,
  input  fqi_pkg::value_t   new_value,
  input  fqi_pkg::value_t   left_value,
  input  fqi_pkg::value_t   right_value,
  output fqi_pkg::value_t   value
);

  fqi_pkg::value_t data_r;
  fqi_pkg::value_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd)
      fqi_pkg::CMD_PUT: begin
        if (idx == pos) begin
          data_nxt = new_value;
        end else if (idx > pos) begin
          data_nxt = left_value;
        end
      end
      fqi_pkg::CMD_POP: begin
        data_nxt = right_value;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign value = data_r;

endmodule

// ===== src/fifo_queue_with_positional_insert_top.sv =====
// fifo_queue_with_positional_insert_top: bounded queue with insert at position
// row of fqi_cell slots, head in slot 0; depends on fqi_pkg and fqi_cell
//
//   channel | ports                                         | direction
//   in      | in_valid in_stall in_mode in_value in_position | request word in
//   out     | out_valid out_stall out_removed_value          | result word out
//           | out_status out_occupancy                       |
//
// one request per cycle while in_stall is low; the result is formed combinationally
// and loaded into the output register on the accepting edge
// all slots shift or load in parallel on the accepting edge
// reset clears count and output valid; slot contents are left as they are
// in_stall is high while a result sits in the output register and out_stall is high
`timescale 1ns / 1ps
module fifo_queue_with_positional_insert_top #(
  parameter int DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fqi_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [fqi_pkg::VALUE_W-1:0] in_value,
  input  logic [fqi_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fqi_pkg::VALUE_W-1:0] out_removed_value,
  output logic [fqi_pkg::STAT_W-1:0]         out_status,
  output logic [fqi_pkg::OCC_W-1:0]          out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > fqi_pkg::POS_W) ? CW : fqi_pkg::POS_W;

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             out_valid_r;
  fqi_pkg::value_t  out_removed_value_r;
  logic [fqi_pkg::STAT_W-1:0] out_status_r;
  logic [fqi_pkg::OCC_W-1:0]  out_occupancy_r;

  logic               accept;
  logic               full;
  logic               empty;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      cnt_ext;
  logic [PW-1:0]      put_pos;
  fqi_pkg::cell_cmd_t cmd;
  fqi_pkg::value_t    removed;
  logic [fqi_pkg::STAT_W-1:0] status;
  fqi_pkg::value_t    slot [DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(count_r);

  always_comb begin
    cmd       = fqi_pkg::CMD_NONE;
    put_pos   = cnt_ext;
    removed   = fqi_pkg::NO_VALUE;
    status    = fqi_pkg::ST_OK;
    count_nxt = count_r;
    case (in_mode)
      fqi_pkg::MODE_ENQUEUE: begin
        if (full) begin
          status = fqi_pkg::ST_FULL;
        end else begin
          cmd       = fqi_pkg::CMD_PUT;
          count_nxt = count_r + 1'b1;
        end
      end
      fqi_pkg::MODE_DEQUEUE: begin
        if (empty) begin
          status = fqi_pkg::ST_EMPTY;
        end else begin
          cmd       = fqi_pkg::CMD_POP;
          removed   = slot[0];
          count_nxt = count_r - 1'b1;
        end
      end
      fqi_pkg::MODE_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = fqi_pkg::ST_RANGE;
        end else if (full) begin
          status = fqi_pkg::ST_FULL;
        end else begin
          cmd       = fqi_pkg::CMD_PUT;
          put_pos   = pos_ext;
          count_nxt = count_r + 1'b1;
        end
      end
      default: begin
        cmd = fqi_pkg::CMD_NONE;
      end
    endcase
    if (!accept) begin
      cmd       = fqi_pkg::CMD_NONE;
      count_nxt = count_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fqi_cell #(
      .PW(PW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (put_pos),
      .idx        (PW'(i)),
      .new_value  (in_value),
      .left_value ((i == 0) ? slot[i] : slot[(i == 0) ? 0 : i - 1]),
      .right_value((i == DEPTH - 1) ? slot[i] : slot[(i == DEPTH - 1) ? i : i + 1]),
      .value      (slot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_removed_value_r <= removed;
      out_status_r        <= status;
      out_occupancy_r     <= fqi_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_value_r;
  assign out_status        = out_status_r;
  assign out_occupancy     = out_occupancy_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count above depth");

  a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word gave no result");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == fqi_pkg::ST_EMPTY |-> out_occupancy_r == '0)
    else $error("empty status with nonzero occupancy");

  a_no_pop_value: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd != fqi_pkg::CMD_POP |=> out_removed_value_r == fqi_pkg::NO_VALUE)
    else $error("removed value set without a pop");
`endif

endmodule
